// File: rtl/core/aes_pkg.sv
// AES-128 package: S-box tables, GF(2^8) helpers, round step functions and key schedule.
// No dependencies.
package aes_pkg;

    localparam int NumRounds = 10;
    localparam logic [0:0] OpEncrypt = 1'b0;
    localparam logic [0:0] OpDecrypt = 1'b1;
    localparam logic [0:0] CfgKeyHigh = 1'b0;
    localparam logic [0:0] CfgKeyLow  = 1'b1;

    typedef logic [127:0] t_block;
    typedef logic [3:0]   t_round;

    typedef struct packed {
        logic   valid;
        logic   op;
        t_block data;
    } t_cell_bus;

    function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] rcon(input t_round r);
        logic [7:0] c;
        unique case (r)
            4'd0: c = 8'h01;  4'd1: c = 8'h02;  4'd2: c = 8'h04;  4'd3: c = 8'h08;
            4'd4: c = 8'h10;  4'd5: c = 8'h20;  4'd6: c = 8'h40;  4'd7: c = 8'h80;
            4'd8: c = 8'h1b;  4'd9: c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block sits at bits 127-8i
    function automatic logic [7:0] get_b(input t_block s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic t_block key_next(input t_block k, input t_round r);
        logic [31:0] w0, w1, w2, w3, t;
        t_block o;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox_fwd(w3[23:16]) ^ rcon(r), sbox_fwd(w3[15:8]),
             sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
        o[127:96] = w0 ^ t;
        o[95:64]  = w1 ^ o[127:96];
        o[63:32]  = w2 ^ o[95:64];
        o[31:0]   = w3 ^ o[63:32];
        return o;
    endfunction

    function automatic t_block enc_round(input t_block s, input logic last);
        t_block sr, o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sr[127 - 8 * (c * 4 + r) -: 8] = sbox_fwd(get_b(s, ((c + r) % 4) * 4 + r));
        o = sr;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_b(sr, c * 4); a1 = get_b(sr, c * 4 + 1);
                a2 = get_b(sr, c * 4 + 2); a3 = get_b(sr, c * 4 + 3);
                o[127 - 8 * (c * 4) -: 8]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                o[127 - 8 * (c * 4 + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                o[127 - 8 * (c * 4 + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                o[127 - 8 * (c * 4 + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        return o;
    endfunction

    // inverse shift rows and sub bytes; the round key is added by the caller
    function automatic t_block dec_sub(input t_block s);
        t_block o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8 * (c * 4 + r) -: 8] = sbox_inv(get_b(s, ((c + 4 - r) % 4) * 4 + r));
        return o;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block o;
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [7:0] m9 [4];
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j] = get_b(s, c * 4 + j);
                m2[j] = xt(a[j]); m4[j] = xt(m2[j]); m8[j] = xt(m4[j]);
                m9[j] = m8[j] ^ a[j];
            end
            for (int r = 0; r < 4; r++)
                o[127 - 8 * (c * 4 + r) -: 8] =
                    (m8[r] ^ m4[r] ^ m2[r])                       // 0e
                  ^ (m9[(r + 1) % 4] ^ m2[(r + 1) % 4])           // 0b
                  ^ (m9[(r + 2) % 4] ^ m4[(r + 2) % 4])           // 0d
                  ^ m9[(r + 3) % 4];                              // 09
        end
        return o;
    endfunction

endpackage

// File: rtl/core/aes_if.sv
// Valid/ready item channel carrying a generic payload type, and a valid/ready config write channel.
// No dependencies; the payload type is a parameter.
interface aes_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/aes_key_cell.sv
// Key schedule cell: registers the next round key from its incoming key and hands it forward.
// Depends on aes_pkg.
module aes_key_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  aes_pkg::t_round i_round,
    input  aes_pkg::t_block i_key,
    output aes_pkg::t_block o_key
);
    import aes_pkg::*;
    t_block r_key;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key <= key_next(i_key, i_round);
        end
    end
    assign o_key = r_key;
endmodule

// File: rtl/core/aes_round_cell.sv
// One cipher round cell: registers the state after one encryption or inverse round.
// Depends on aes_pkg; round keys arrive from the key chain.
module aes_round_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_last,
    input  aes_pkg::t_block   i_enc_key,
    input  aes_pkg::t_block   i_dec_key,
    input  aes_pkg::t_cell_bus i_bus,
    output aes_pkg::t_cell_bus o_bus
);
    import aes_pkg::*;
    t_cell_bus r_bus;
    t_block    n_data;
    t_block    w_dec;

    always_comb begin
        w_dec = dec_sub(i_bus.data) ^ i_dec_key;
        if (i_bus.op == OpEncrypt) begin
            n_data = enc_round(i_bus.data, i_last) ^ i_enc_key;
        end else if (i_last) begin
            n_data = w_dec;
        end else begin
            n_data = inv_mix(w_dec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus.valid <= i_bus.valid;
        end
        if (i_en) begin
            r_bus.op   <= i_bus.op;
            r_bus.data <= n_data;
        end
    end
    assign o_bus = r_bus;
endmodule

// File: rtl/core/aes128_block_cipher_top.sv
// AES-128 cipher, ten round cells in a chain, one item per cycle unless stalled.
// Depends on aes_pkg, aes_if, aes_round_cell, aes_key_cell.
//
// Takes one block per clock while not stalled and passes it through the input add-key
// stage and ten round cells. The whole chain advances together and stalls only when the
// last cell holds a result that the sink has not taken. Round keys are expanded by the key
// cells after each key write and after reset; the input is held not ready until they settle.
module aes128_block_cipher_top
    import aes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    aes_cfg_if.sink                      i_cfg,
    aes_stream_if.sink                   i_in,
    aes_stream_if.source                 o_out
);
    t_block r_key0;
    t_block w_rk [NumRounds + 1];
    t_cell_bus w_bus [NumRounds + 1];
    t_cell_bus r_in;
    t_round r_settle;
    logic w_key_ok;
    logic w_en;
    logic w_cfg_we;

    assign w_cfg_we = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
        end else if (w_cfg_we) begin
            if (i_cfg.index == CfgKeyHigh) begin
                r_key0[127:64] <= i_cfg.wdata;
            end else begin
                r_key0[63:0] <= i_cfg.wdata;
            end
        end
    end

    // cycles left until the last round key reflects the key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_we) begin
            r_settle <= t_round'(NumRounds);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end
    assign w_key_ok = (r_settle == '0);

    // key chain runs free; settles while r_settle counts down after a write
    assign w_rk[0] = r_key0;
    for (genvar g = 0; g < NumRounds; g++) begin : g_key
        aes_key_cell u_key (
            .i_clk(i_clk), .i_en(1'b1), .i_round(t_round'(g)),
            .i_key(w_rk[g]), .o_key(w_rk[g + 1])
        );
    end

    assign w_en = !w_bus[NumRounds].valid || o_out.ready;
    assign i_in.ready = w_en && w_key_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= i_in.valid && w_key_ok;
        end
        if (w_en) begin
            r_in.op   <= i_in.data.op;
            r_in.data <= i_in.data.data ^
                         ((i_in.data.op == OpEncrypt) ? w_rk[0] : w_rk[NumRounds]);
        end
    end
    assign w_bus[0] = r_in;

    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        aes_round_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_last(g == NumRounds - 1),
            .i_enc_key(w_rk[g + 1]), .i_dec_key(w_rk[NumRounds - 1 - g]),
            .i_bus(w_bus[g]), .o_bus(w_bus[g + 1])
        );
    end

    assign o_out.valid = w_bus[NumRounds].valid;
    assign o_out.data  = w_bus[NumRounds].data;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("result changed under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while chain stalled");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_in.valid |=> w_bus[1].valid)
        else $error("item lost in first cell");
endmodule
